### sv/ttd_pkg.sv
// ----------------------------------------------------------------------------
// Timed task dispatcher package
// Command and status codes, default sizes and the control structures shared
// between the top level and the ready queue.
// ----------------------------------------------------------------------------
package ttd_pkg;

	localparam int READY_DEPTH_DEF = 16;
	localparam int TIMER_SLOTS_DEF = 8;

	localparam int TASK_W  = 8;
	localparam int DELAY_W = 16;
	localparam int FIRED_W = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		CMD_POST         = 2'd0,
		CMD_POST_DELAYED = 2'd1,
		CMD_DISPATCH     = 2'd2,
		CMD_TICK         = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_NO_SLOT = 2'd2
	} status_e_t;

	// Requests from the sequencer to the ready queue.
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [TASK_W-1:0] push_task;
	} fifo_ctrl_t;

	// Occupancy flags reported back by the ready queue.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

### sv/ttd_req_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Carries one command word: the command code, a task identifier and a delay.
// ----------------------------------------------------------------------------
interface ttd_req_if import ttd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [TASK_W-1:0]  task_id;
	logic [DELAY_W-1:0] delay_ticks;

	modport source (output valid, output cmd, output task_id, output delay_ticks, input ready);
	modport sink   (input valid, input cmd, input task_id, input delay_ticks, output ready);
endinterface

### sv/ttd_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one result word per command.
// ----------------------------------------------------------------------------
interface ttd_rsp_if import ttd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TASK_W-1:0]  dispatched_task;
	logic               dispatch_valid;
	logic [1:0]         status;
	logic [FIRED_W-1:0] fired_count;
	logic [COUNT_W-1:0] ready_count;

	modport source (output valid, output dispatched_task, output dispatch_valid,
		output status, output fired_count, output ready_count, input ready);
	modport sink   (input valid, input dispatched_task, input dispatch_valid,
		input status, input fired_count, input ready_count, output ready);
endinterface

### sv/ttd_ready_fifo.sv
// ----------------------------------------------------------------------------
// Ready task queue
// Ring buffer of task identifiers in a synchronous memory, with head, tail
// and fill registers. A pop delivers its data in the following cycle.
// ----------------------------------------------------------------------------
module ttd_ready_fifo import ttd_pkg::*; #(
	parameter int READY_DEPTH = READY_DEPTH_DEF,
	localparam int FIFO_AW    = $clog2(READY_DEPTH),
	localparam int FILL_W     = $clog2(READY_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fifo_ctrl_t        ctrl,
	output fifo_stat_t        stat,
	output logic [FILL_W-1:0] fill,
	output logic [TASK_W-1:0] rd_task
);

	logic [TASK_W-1:0]  mem [READY_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW-1:0] tail_q;
	logic [FILL_W-1:0]  fill_q;
	logic [TASK_W-1:0]  rd_task_s2;
	logic               push_ok;
	logic               pop_ok;

	function automatic logic [FIFO_AW-1:0] ptr_next(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(READY_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ok = ctrl.push && (fill_q != FILL_W'(READY_DEPTH));
	assign pop_ok  = ctrl.pop && (fill_q != '0);

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[tail_q] <= ctrl.push_task;
		end
		if (pop_ok) begin
			rd_task_s2 <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push_ok) begin
				tail_q <= ptr_next(tail_q);
			end
			if (pop_ok) begin
				head_q <= ptr_next(head_q);
			end
			if (push_ok && !pop_ok) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign stat.full  = (fill_q == FILL_W'(READY_DEPTH));
	assign stat.empty = (fill_q == '0);
	assign fill       = fill_q;
	assign rd_task    = rd_task_s2;

endmodule

### sv/timed_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// Timed task dispatcher
// Ready task queue plus a table of timer slots, driven by four commands.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as words on the req channel (post, post delayed,
// dispatch, tick) and every command returns exactly one result word on the
// rsp channel, in order. Words move when valid and ready are both high.
// The block works on one command at a time. Post and dispatch pass through
// their own work state and then the emit state, which loads the result word
// into the output register; a new command is taken only once the block is
// back in idle. Post delayed and tick walk the timer slot memory one slot
// per cycle, because the slots sit in a synchronous memory with registered
// read data and separate read and write ports. A tick walks every slot,
// and post delayed stops at the first free slot.
// If the receiver stalls, the finished result waits in the output register
// and a following command completes its work but holds its result until
// the register frees up.
// Reset empties the ready queue and frees every timer slot at once: each
// slot has a valid flag, and a slot without it reads as idle task, zero
// delay. No clearing pass is needed.
// ----------------------------------------------------------------------------
module timed_task_dispatcher_unit import ttd_pkg::*; #(
	parameter int READY_DEPTH = READY_DEPTH_DEF,
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	ttd_req_if.sink   req,
	ttd_rsp_if.source rsp
);

	localparam int FILL_W  = $clog2(READY_DEPTH + 1);
	localparam int SLOT_CW = $clog2(TIMER_SLOTS + 1);
	localparam int SLOT_AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int SLOT_W  = TASK_W + DELAY_W;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POST = 5'b00010,
		S_DISP = 5'b00100,
		S_WALK = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t             state_q;
	cmd_e_t             cmd_q;
	logic [TASK_W-1:0]  task_q;
	logic [DELAY_W-1:0] delay_q;
	status_e_t          status_q;
	logic [SLOT_CW-1:0] fired_q;
	logic               disp_vld_q;

	// Timer slot memory and its per-slot valid flags.
	logic [SLOT_W-1:0]      slot_mem [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] slot_vld_q;
	logic [SLOT_CW-1:0]     rd_idx_q;
	logic [SLOT_W-1:0]      slot_rd_s2;
	logic                   slot_hit_s2;
	logic                   proc_vld_s2;
	logic [SLOT_AW-1:0]     proc_idx_s2;

	logic               slot_rd_en;
	logic [SLOT_AW-1:0] slot_ra;
	logic               slot_we;
	logic [SLOT_W-1:0]  slot_wd;
	logic               vld_clr;
	logic [TASK_W-1:0]  cur_task;
	logic [DELAY_W-1:0] cur_delay;
	logic               last_slot;
	logic               found;
	logic               fire;
	logic               walk_done;

	// Ready queue.
	fifo_ctrl_t         fifo_ctrl;
	fifo_stat_t         fifo_stat;
	logic [FILL_W-1:0]  fifo_fill;
	logic [TASK_W-1:0]  fifo_rd;

	// Output register.
	logic               out_vld_q;
	logic [TASK_W-1:0]  out_task_q;
	logic               out_disp_vld_q;
	status_e_t          out_status_q;
	logic [FIRED_W-1:0] out_fired_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               can_emit;
	logic               accept;

	ttd_ready_fifo #(
		.READY_DEPTH (READY_DEPTH)
	) u_ready_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (fifo_ctrl),
		.stat    (fifo_stat),
		.fill    (fifo_fill),
		.rd_task (fifo_rd)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign can_emit  = !out_vld_q || rsp.ready;

	// The walk reads slot i+1 while slot i is being written back, so a read
	// and a write never touch the same entry and no forwarding is required.
	assign slot_rd_en = (state_q == S_WALK) && (rd_idx_q < SLOT_CW'(TIMER_SLOTS)) && !walk_done;
	assign slot_ra    = rd_idx_q[SLOT_AW-1:0];

	assign cur_task  = slot_hit_s2 ? slot_rd_s2[SLOT_W-1:DELAY_W] : '0;
	assign cur_delay = slot_hit_s2 ? slot_rd_s2[DELAY_W-1:0] : '0;
	assign last_slot = (proc_idx_s2 == SLOT_AW'(TIMER_SLOTS - 1));

	always_comb begin
		slot_we   = 1'b0;
		slot_wd   = {cur_task, cur_delay};
		vld_clr   = 1'b0;
		found     = 1'b0;
		fire      = 1'b0;
		walk_done = 1'b0;
		if ((state_q == S_WALK) && proc_vld_s2) begin
			if (cmd_q == CMD_POST_DELAYED) begin
				if (cur_task == '0) begin
					// Lowest free slot takes the task, even the idle task.
					found   = 1'b1;
					slot_we = 1'b1;
					slot_wd = {task_q, delay_q};
				end
			end else if (cur_task != '0) begin
				if (cur_delay != '0) begin
					slot_we = 1'b1;
					slot_wd = {cur_task, cur_delay - 1'b1};
				end else begin
					fire    = 1'b1;
					vld_clr = 1'b1;
				end
			end
			walk_done = found || last_slot;
		end
	end

	always_comb begin
		fifo_ctrl.push      = 1'b0;
		fifo_ctrl.pop       = 1'b0;
		fifo_ctrl.push_task = task_q;
		unique case (state_q)
			S_POST: begin
				fifo_ctrl.push = 1'b1;
			end
			S_DISP: begin
				fifo_ctrl.pop = 1'b1;
			end
			S_WALK: begin
				fifo_ctrl.push      = fire;
				fifo_ctrl.push_task = cur_task;
			end
			S_IDLE, S_EMIT: begin
				fifo_ctrl.push = 1'b0;
			end
			default: begin
				fifo_ctrl.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[proc_idx_s2] <= slot_wd;
		end
		if (slot_rd_en) begin
			slot_rd_s2 <= slot_mem[slot_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_e_t'(req.cmd);
			task_q  <= req.task_id;
			delay_q <= req.delay_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			fired_q     <= '0;
			disp_vld_q  <= 1'b0;
			slot_vld_q  <= '0;
			rd_idx_q    <= '0;
			slot_hit_s2 <= 1'b0;
			proc_vld_s2 <= 1'b0;
			proc_idx_s2 <= '0;
		end else begin
			proc_vld_s2 <= slot_rd_en;
			if (slot_rd_en) begin
				slot_hit_s2 <= slot_vld_q[slot_ra];
				proc_idx_s2 <= slot_ra;
				rd_idx_q    <= rd_idx_q + 1'b1;
			end
			if (slot_we) begin
				slot_vld_q[proc_idx_s2] <= 1'b1;
			end else if (vld_clr) begin
				slot_vld_q[proc_idx_s2] <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						fired_q    <= '0;
						disp_vld_q <= 1'b0;
						rd_idx_q   <= '0;
						status_q   <= (cmd_e_t'(req.cmd) == CMD_POST_DELAYED) ? ST_NO_SLOT : ST_OK;
						case (cmd_e_t'(req.cmd))
							CMD_POST:     state_q <= S_POST;
							CMD_DISPATCH: state_q <= S_DISP;
							default:      state_q <= S_WALK;
						endcase
					end
				end
				S_POST: begin
					if (fifo_stat.full) begin
						status_q <= ST_DROPPED;
					end
					state_q <= S_EMIT;
				end
				S_DISP: begin
					disp_vld_q <= !fifo_stat.empty;
					state_q    <= S_EMIT;
				end
				S_WALK: begin
					if (found) begin
						status_q <= ST_OK;
					end
					if (fire) begin
						fired_q <= fired_q + 1'b1;
						if (fifo_stat.full) begin
							status_q <= ST_DROPPED;
						end
					end
					if (walk_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: loaded when a command finishes, held while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == S_EMIT) && can_emit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && can_emit) begin
			out_task_q     <= disp_vld_q ? fifo_rd : '0;
			out_disp_vld_q <= disp_vld_q;
			out_status_q   <= status_q;
			out_fired_q    <= (32'(fired_q) > 32'd15) ? 4'd15 : FIRED_W'(fired_q);
			out_count_q    <= (32'(fifo_fill) > 32'd31) ? 5'd31 : COUNT_W'(fifo_fill);
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.dispatched_task = out_task_q;
	assign rsp.dispatch_valid  = out_disp_vld_q;
	assign rsp.status          = out_status_q;
	assign rsp.fired_count     = out_fired_q;
	assign rsp.ready_count     = out_count_q;

	// The queue never holds more tasks than it has entries.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fifo_fill) <= READY_DEPTH)
		else $error("ready queue fill exceeds its depth");

	// A write-back never lands on the entry being read in the same cycle.
	a_no_slot_clash: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we && slot_rd_en |-> proc_idx_s2 != slot_ra)
		else $error("timer slot read and write collide");

	// A successful dispatch reports neither a fault nor fired slots.
	a_disp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_disp_vld_q |-> out_status_q == ST_OK && out_fired_q == '0)
		else $error("dispatch result carries tick or post status");

	// A slot found free by a delayed post is occupied on the next cycle.
	a_slot_taken: assert property (@(posedge clk) disable iff (!arst_n)
		found |=> slot_vld_q[$past(proc_idx_s2)])
		else $error("delayed post did not mark its slot");

endmodule
